/* src/sesf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline edge span fill package
// Shared widths, mode codes and payload types for the span fill core.
// ----------------------------------------------------------------------------
package sesf_pkg;
  localparam int Rows      = 512;
  localparam int RowW      = $clog2(Rows);
  localparam int FracBits  = 16;
  localparam int PixW      = 9;
  localparam int EdgeW     = PixW + 1 + FracBits;
  localparam int ScreenW   = 500;
  localparam int DivW      = PixW + FracBits;

  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeEdge  = 2'd1;
  localparam logic [1:0] ModeQuery = 2'd2;
  // Unused mode: ignored by the core.
  localparam logic [1:0] ModeNone  = 2'd3;

  localparam logic [EdgeW-1:0] LeftReset = EdgeW'(ScreenW) << FracBits;

  typedef struct packed {
    logic [1:0]      mode;
    logic [PixW-1:0] x_start;
    logic [PixW-1:0] y_start;
    logic [PixW-1:0] x_end;
    logic [PixW-1:0] y_end;
    logic [PixW-1:0] query_row;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] span_row;
    logic [9:0]      span_first;
    logic [9:0]      span_end;
    logic            span_empty;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [PixW-1:0] divisor;
  } div_req_t;
endpackage

/* src/sesf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span fill channel interfaces
// Valid/ready channels carrying an input item and a result item.
// ----------------------------------------------------------------------------
interface sesf_in_if;
  import sesf_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sesf_out_if;
  import sesf_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/sesf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span fill slope divider
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module sesf_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sesf_pkg::div_req_t              req,
  output logic                            done,
  output logic [sesf_pkg::DivW-1:0]       quot
);
  import sesf_pkg::*;

  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0] q_r, q_nxt;
  logic [PixW:0]   rem_r, rem_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [PixW-1:0] dvs_r, dvs_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [PixW:0]   trial;

  // Shift in the next dividend bit and try one subtraction.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    dvs_nxt  = dvs_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[PixW-1:0], q_r[DivW-1]};
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = CntW'(DivW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt   = {q_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

/* src/scanline_edge_span_fill_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline edge span fill core
// Per-row left/right edge table; edges are walked row by row, spans queried.
// ----------------------------------------------------------------------------
// Sequence: clear writes all 512 rows (one row per cycle); an edge runs
// a slope division (skipped for a horizontal edge), then a read state and
// a write state per walked row; a query reads its row, then gives a
// registered result. One item at a time; in_ready is low while an item is
// at work. Reset starts the same clearing pass before the first item.
module scanline_edge_span_fill_core (
  input logic   clk,
  input logic   rst_n,
  sesf_in_if.sink    in_ch,
  sesf_out_if.source out_ch
);
  import sesf_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StClear = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StWrite = 3'd4;
  localparam logic [2:0] StQRead = 3'd5;
  localparam logic [2:0] StQOut  = 3'd6;

  localparam int AccW = EdgeW + 1;

  logic [EdgeW-1:0] left_mem  [Rows];
  logic [EdgeW-1:0] right_mem [Rows];

  logic [2:0]       st_r, st_nxt;
  logic [PixW:0]    row_r, row_nxt;
  logic [PixW-1:0]  yend_r, yend_nxt;
  logic [AccW-1:0]  acc_r, acc_nxt;
  logic [AccW-1:0]  step_r, step_nxt;
  logic             neg_r, neg_nxt;
  logic [PixW-1:0]  qrow_r, qrow_nxt;
  logic [EdgeW-1:0] lrd_r, rrd_r;
  logic             ovalid_r, ovalid_nxt;
  out_item_t        odata_r, odata_nxt;

  logic             we;
  logic [RowW-1:0]  waddr, raddr;
  logic [EdgeW-1:0] wl, wr;
  div_req_t         dreq;
  logic             ddone;
  logic [DivW-1:0]  dquot;

  // Endpoint ordering and deltas for an incoming edge.
  logic             swap;
  logic [PixW-1:0]  xa, ya, xb, yb, adx, dy;
  logic             dxneg;
  always_comb begin
    swap  = in_ch.data.y_end < in_ch.data.y_start;
    xa    = swap ? in_ch.data.x_end : in_ch.data.x_start;
    ya    = swap ? in_ch.data.y_end : in_ch.data.y_start;
    xb    = swap ? in_ch.data.x_start : in_ch.data.x_end;
    yb    = swap ? in_ch.data.y_start : in_ch.data.y_end;
    dxneg = xb < xa;
    adx   = dxneg ? xa - xb : xb - xa;
    dy    = yb - ya;
  end

  sesf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .done (ddone),
    .quot (dquot)
  );

  logic [EdgeW-1:0] cur;
  logic [FracBits-1:0] qfrac;
  logic [EdgeW-1:0] ceil_v;
  always_comb begin
    cur    = acc_r[EdgeW-1:0];
    qfrac  = '1;
    ceil_v = rrd_r + EdgeW'(qfrac);
  end

  // Sequencer.
  always_comb begin
    st_nxt     = st_r;
    row_nxt    = row_r;
    yend_nxt   = yend_r;
    acc_nxt    = acc_r;
    step_nxt   = step_r;
    neg_nxt    = neg_r;
    qrow_nxt   = qrow_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    dreq       = '0;
    we         = 1'b0;
    waddr      = row_r[RowW-1:0];
    raddr      = row_r[RowW-1:0];
    wl         = LeftReset;
    wr         = '0;
    in_ch.ready = (st_r == StIdle) && !ovalid_r;
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    case (st_r)
      StIdle: begin
        if (in_ch.valid && in_ch.ready) begin
          case (in_ch.data.mode)
            ModeClear: begin
              row_nxt = '0;
              st_nxt  = StClear;
            end
            ModeEdge: begin
              row_nxt  = {1'b0, ya};
              yend_nxt = yb;
              acc_nxt  = AccW'(xa) << FracBits;
              neg_nxt  = dxneg;
              if (dy == '0) begin
                step_nxt = dxneg ? -(AccW'(adx) << FracBits) : AccW'(adx) << FracBits;
                st_nxt   = StRead;
              end else begin
                dreq.start    = 1'b1;
                dreq.dividend = DivW'(adx) << FracBits;
                dreq.divisor  = dy;
                st_nxt        = StDiv;
              end
            end
            ModeQuery: begin
              qrow_nxt = in_ch.data.query_row;
              st_nxt   = StQRead;
            end
            default: st_nxt = StIdle;
          endcase
        end
      end
      StClear: begin
        we      = 1'b1;
        row_nxt = row_r + (PixW+1)'(1);
        if (row_r == (PixW+1)'(Rows - 1)) st_nxt = StIdle;
      end
      StDiv: begin
        if (ddone) begin
          step_nxt = neg_r ? -AccW'(dquot) : AccW'(dquot);
          st_nxt   = StRead;
        end
      end
      StRead: st_nxt = StWrite;
      StWrite: begin
        we      = 1'b1;
        wl      = (cur < lrd_r) ? cur : lrd_r;
        wr      = (cur > rrd_r) ? cur : rrd_r;
        acc_nxt = acc_r + step_r;
        row_nxt = row_r + (PixW+1)'(1);
        st_nxt  = (row_r[PixW-1:0] == yend_r) ? StIdle : StRead;
      end
      StQRead: begin
        raddr  = qrow_r[RowW-1:0];
        st_nxt = StQOut;
      end
      StQOut: begin
        odata_nxt.span_row   = qrow_r;
        odata_nxt.span_first = 10'(lrd_r >> FracBits);
        odata_nxt.span_end   = 10'(ceil_v >> FracBits);
        odata_nxt.span_empty = odata_nxt.span_first >= odata_nxt.span_end;
        ovalid_nxt = 1'b1;
        st_nxt     = StIdle;
      end
      default: st_nxt = StIdle;
    endcase
  end

  // Edge tables: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      left_mem[waddr]  <= wl;
      right_mem[waddr] <= wr;
    end
    lrd_r <= left_mem[raddr];
    rrd_r <= right_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= StClear;
      row_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      row_r    <= row_nxt;
      ovalid_r <= ovalid_nxt;
    end
    yend_r  <= yend_nxt;
    acc_r   <= acc_nxt;
    step_r  <= step_nxt;
    neg_r   <= neg_nxt;
    qrow_r  <= qrow_nxt;
    odata_r <= odata_nxt;
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;

  // The walked x stays nonnegative.
  a_acc_pos: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == StWrite |-> !acc_r[AccW-1]) else $error("walk x went negative");
  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(odata_r)) else $error("result changed");
  // No item is taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_ch.ready) else $error("ready while result pending");
endmodule
